@@ src/skil_pkg.sv @@
// ---------------------------------------------------------------------------
// skil_pkg: shared types and constants of the sorted key index lookup
// Command codes, controller-to-datapath command and status bundles, table
// entry layout and the fixed field widths of the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package skil_pkg;

  // Default table depth and fixed field widths.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned OFFSET_W        = 32;
  localparam int unsigned LENGTH_W        = 16;
  localparam int unsigned FPOS_W          = 33;
  localparam int unsigned ENTRY_COUNT_W   = 11;

  // Configuration port: one 32-bit register at byte address 0.
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic        REG_DATA_BOUND = 1'b0;

  // File position is (2*count+3)*8 + offset = count*16 + 24 + offset.
  localparam int unsigned FPOS_COUNT_SHIFT = 4;
  localparam int unsigned FPOS_HEADER      = 24;

  // The probe loop narrows the window while it spans more than this.
  localparam int unsigned PROBE_SPAN_MIN = 2;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_APPEND   = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_e;

  // Window update of the binary search.
  typedef enum logic [1:0] {
    BND_HOLD = 2'd0,
    BND_INIT = 2'd1,
    BND_STEP = 2'd2
  } bnd_e;

  // Kind of result loaded into the result registers.
  typedef enum logic [2:0] {
    RSP_NONE   = 3'd0,
    RSP_CLEAR  = 3'd1,
    RSP_APPEND = 3'd2,
    RSP_ZERO   = 3'd3,
    RSP_HIT    = 3'd4
  } rsp_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch;
    bnd_e bnd;
    logic addr_last;
    rsp_e rsp;
  } skil_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic more;
    logic key_eq;
    logic cnt_zero;
  } skil_sts_t;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
  } entry_t;

endpackage

@@ src/sorted_key_index_lookup.sv @@
// ---------------------------------------------------------------------------
// sorted_key_index_lookup: sorted string table index with binary search
// Channel    | Signals                                          | Direction
// request    | start, busy, cmd_i, key_i, value_length_i        | in/out
// result     | done_o, ok_o, found_o, value_offset_o,            | out
//            | value_bytes_o, file_position_o, entry_count_o     |
// config     | psel, penable, pwrite, paddr, pwdata, prdata,     | in/out
//            | pready (data_bound at byte address 0)             |
//
// A request is taken when start is high and busy is low; its result is
// strobed on done_o in the cycle after the request finishes.
// Clear, append and reserved requests finish in the accept cycle.
// A lookup reads the entry memory once per probe: about log2(count) - 1
// probes plus two end checks.
// Reset empties the table and sets data_bound to all ones.
// done_o is high for one cycle only; the receiver cannot stall it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_index_lookup
  import skil_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd_i,
  input  logic [KEY_W-1:0]         key_i,
  input  logic [LENGTH_W-1:0]      value_length_i,
  output logic                     done_o,
  output logic                     ok_o,
  output logic                     found_o,
  output logic [OFFSET_W-1:0]      value_offset_o,
  output logic [LENGTH_W-1:0]      value_bytes_o,
  output logic [FPOS_W-1:0]        file_position_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  skil_cmd_t           ctl;
  skil_sts_t           sts;
  logic [OFFSET_W-1:0] bound_q;
  logic                cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_DATA_BOUND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '1;
    end else if (cfg_wr) begin
      bound_q <= pwdata;
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_DATA_BOUND) ? bound_q : '0;

  // Request sequencer.
  skil_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy),
    .cmd_i   (cmd_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  // Table storage, search and result registers.
  skil_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .key_i           (key_i),
    .value_length_i  (value_length_i),
    .bound_i         (bound_q),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .found_o         (found_o),
    .value_offset_o  (value_offset_o),
    .value_bytes_o   (value_bytes_o),
    .file_position_o (file_position_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

@@ src/skil_ctrl.sv @@
// ---------------------------------------------------------------------------
// skil_ctrl: request sequencer of the sorted key index lookup
// Decodes requests and steps the binary search: probe loop, then a check of
// the lower and the upper end of the final window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module skil_ctrl
  import skil_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] cmd_i,
  input  skil_sts_t  sts_i,
  output skil_cmd_t  ctl_o,
  output logic       busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LOOP  = 2'd1,
    ST_CHK_L = 2'd2,
    ST_CHK_R = 2'd3
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    ctl_o.latch     = 1'b0;
    ctl_o.bnd       = BND_HOLD;
    ctl_o.addr_last = 1'b0;
    ctl_o.rsp       = RSP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          case (cmd_i)
            CMD_CLEAR:  ctl_o.rsp = RSP_CLEAR;
            CMD_APPEND: ctl_o.rsp = RSP_APPEND;
            CMD_LOOKUP: begin
              if (sts_i.cnt_zero) begin
                ctl_o.rsp = RSP_ZERO;
              end else begin
                ctl_o.bnd = BND_INIT;
                state_d   = sts_i.more ? ST_LOOP : ST_CHK_L;
              end
            end
            default: ctl_o.rsp = RSP_ZERO;
          endcase
        end
      end
      ST_LOOP: begin
        if (sts_i.key_eq) begin
          ctl_o.rsp = RSP_HIT;
          state_d   = ST_IDLE;
        end else begin
          ctl_o.bnd = BND_STEP;
          state_d   = sts_i.more ? ST_LOOP : ST_CHK_L;
        end
      end
      ST_CHK_L: begin
        if (sts_i.key_eq) begin
          ctl_o.rsp = RSP_HIT;
          state_d   = ST_IDLE;
        end else begin
          ctl_o.addr_last = 1'b1;
          state_d         = ST_CHK_R;
        end
      end
      ST_CHK_R: begin
        ctl_o.rsp = sts_i.key_eq ? RSP_HIT : RSP_ZERO;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ src/skil_dpath.sv @@
// ---------------------------------------------------------------------------
// skil_dpath: datapath of the sorted key index lookup
// Holds the entry memory, count and running offset, the search window and
// the key comparator, and registers each result for one strobe cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module skil_dpath
  import skil_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [KEY_W-1:0]         key_i,
  input  logic [LENGTH_W-1:0]      value_length_i,
  input  logic [OFFSET_W-1:0]      bound_i,
  input  skil_cmd_t                ctl_i,
  output skil_sts_t                sts_o,
  output logic                     done_o,
  output logic                     ok_o,
  output logic                     found_o,
  output logic [OFFSET_W-1:0]      value_offset_o,
  output logic [LENGTH_W-1:0]      value_bytes_o,
  output logic [FPOS_W-1:0]        file_position_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  entry_t              entry_mem [TABLE_DEPTH];
  entry_t              rd_q;
  logic [KEY_W-1:0]    key_q;
  logic [CW-1:0]       count_q, count_d;
  logic [OFFSET_W-1:0] run_q, run_d;
  logic [CW-1:0]       left_q, right_q, left_d, right_d;
  logic [CW-1:0]       probe_q, probe_d;
  logic [CW:0]         span, mid_sum;
  logic                key_lt, key_eq, more;
  logic [OFFSET_W:0]   run_sum;
  logic                app_ok;
  logic [CW-1:0]       cnt_res;
  logic                done_d;

  // Compare the probed key against the search key.
  assign key_lt = (rd_q.key < key_q);
  assign key_eq = (rd_q.key == key_q);

  // Search window update and next probe address.
  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    case (ctl_i.bnd)
      BND_INIT: begin
        left_d  = '0;
        right_d = count_q;
      end
      BND_STEP: begin
        if (key_lt) begin
          left_d = probe_q;
        end else begin
          right_d = probe_q;
        end
      end
      default: ;
    endcase
    span    = {1'b0, right_d} - {1'b0, left_d};
    more    = (span > (CW + 1)'(PROBE_SPAN_MIN));
    mid_sum = ({1'b0, left_d} + {1'b0, right_d}) >> 1;
    if (ctl_i.addr_last) begin
      probe_d = right_q - CW'(1);
    end else if (more) begin
      probe_d = mid_sum[CW-1:0];
    end else begin
      probe_d = left_d;
    end
  end

  assign sts_o.more     = more;
  assign sts_o.key_eq   = key_eq;
  assign sts_o.cnt_zero = (count_q == '0);

  // Append admission check.
  assign run_sum = {1'b0, run_q} + (OFFSET_W + 1)'(value_length_i);
  assign app_ok  = (count_q < CW'(TABLE_DEPTH)) && (run_q <= bound_i) && !run_sum[OFFSET_W];

  // Table state update.
  always_comb begin
    count_d = count_q;
    run_d   = run_q;
    case (ctl_i.rsp)
      RSP_CLEAR: begin
        count_d = '0;
        run_d   = '0;
      end
      RSP_APPEND: begin
        if (app_ok) begin
          count_d = count_q + CW'(1);
          run_d   = run_sum[OFFSET_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Entry memory: one write port for appends, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rsp == RSP_APPEND && app_ok) begin
      entry_mem[count_q[AW-1:0]] <= '{key: key_i, offset: run_q, length: value_length_i};
    end
    rd_q <= entry_mem[probe_d[AW-1:0]];
  end

  // Search registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      key_q <= key_i;
    end
    left_q  <= left_d;
    right_q <= right_d;
    probe_q <= probe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      run_q   <= '0;
    end else begin
      count_q <= count_d;
      run_q   <= run_d;
    end
  end

  // Result registers.
  assign done_d  = (ctl_i.rsp != RSP_NONE);
  assign cnt_res = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      ok_o            <= 1'b0;
      found_o         <= 1'b0;
      value_offset_o  <= '0;
      value_bytes_o   <= '0;
      file_position_o <= '0;
      entry_count_o   <= ENTRY_COUNT_W'(cnt_res);
      case (ctl_i.rsp)
        RSP_CLEAR:  ok_o <= 1'b1;
        RSP_APPEND: ok_o <= app_ok;
        RSP_HIT: begin
          found_o         <= 1'b1;
          value_offset_o  <= rd_q.offset;
          value_bytes_o   <= rd_q.length;
          file_position_o <= (FPOS_W'(count_q) << FPOS_COUNT_SHIFT)
                             + FPOS_W'(FPOS_HEADER) + FPOS_W'(rd_q.offset);
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sim/index_lookup_checker.sv @@
// ---------------------------------------------------------------------------
// index_lookup_checker: result checker for the sorted key index lookup
// Watches the request, result and configuration channels of the block. It
// keeps its own copy of the key table, the value offsets and data_bound,
// works out the answer of every accepted request and compares each strobed
// result field by field with the oldest outstanding answer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module index_lookup_checker
  import skil_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [1:0]               cmd_i,
  input  logic [KEY_W-1:0]         key_i,
  input  logic [LENGTH_W-1:0]      value_length_i,
  input  logic                     done_i,
  input  logic                     ok_i,
  input  logic                     found_i,
  input  logic [OFFSET_W-1:0]      value_offset_i,
  input  logic [LENGTH_W-1:0]      value_bytes_i,
  input  logic [FPOS_W-1:0]        file_position_i,
  input  logic [ENTRY_COUNT_W-1:0] entry_count_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [PADDR_W-1:0]       paddr_i,
  input  logic [PDATA_W-1:0]       pwdata_i,
  input  logic                     pready_i,
  output int unsigned              errors_o,
  output int unsigned              pending_o
);

  localparam logic [PADDR_W-1:0] DATA_BOUND_ADDR = PADDR_W'({REG_DATA_BOUND, 2'b00});
  // The search narrows its window while it spans more than two entries.
  localparam int unsigned SEARCH_SPAN = 2;

  typedef struct packed {
    logic                     ok;
    logic                     found;
    logic [OFFSET_W-1:0]      value_offset;
    logic [LENGTH_W-1:0]      value_bytes;
    logic [FPOS_W-1:0]        file_position;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } answer_t;

  // Shadow copy of the index table and its configuration.
  logic [KEY_W-1:0]    key_table [0:DEPTH-1];
  logic [OFFSET_W-1:0] offset_table [0:DEPTH];
  int unsigned         entries;
  logic [OFFSET_W-1:0] data_end;
  logic [OFFSET_W-1:0] data_bound;

  answer_t     pending_answers [$];
  answer_t     want;
  int unsigned waiting;
  int unsigned mismatches;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  // Same probe order as the block: halve the window, then test both ends.
  function automatic bit search_index(input logic [KEY_W-1:0] k, output int unsigned hit);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    hit = 0;
    lo  = 0;
    hi  = entries;
    if (entries == 0 || entries > DEPTH) return 1'b0;
    while (hi - lo > SEARCH_SPAN) begin
      mid = lo + (hi - lo) / 2;
      if (key_table[mid] < k) begin
        lo = mid;
      end else if (key_table[mid] > k) begin
        hi = mid;
      end else begin
        hit = mid;
        return 1'b1;
      end
    end
    if (key_table[lo] == k) begin
      hit = lo;
      return 1'b1;
    end
    if (key_table[hi-1] == k) begin
      hit = hi - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow table and returns its answer.
  function automatic answer_t predict_answer(input cmd_e op, input logic [KEY_W-1:0] k,
                                             input logic [LENGTH_W-1:0] len);
    answer_t             a;
    logic [OFFSET_W:0]   next_end;
    int unsigned         hit;
    logic [OFFSET_W-1:0] first;
    logic [63:0]         position;
    a = '0;
    case (op)
      CMD_CLEAR: begin
        entries  = 0;
        data_end = '0;
        a.ok     = 1'b1;
      end
      CMD_APPEND: begin
        next_end = {1'b0, data_end} + len;
        if (entries < DEPTH && data_end <= data_bound && !next_end[OFFSET_W]) begin
          key_table[entries]      = k;
          offset_table[entries]   = data_end;
          data_end                = next_end[OFFSET_W-1:0];
          offset_table[entries+1] = data_end;
          entries++;
          a.ok = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (search_index(k, hit)) begin
          first          = offset_table[hit];
          position       = (64'(entries) * 2 + 3) * 8 + first;
          a.found        = 1'b1;
          a.value_offset = first;
          a.value_bytes  = LENGTH_W'(offset_table[hit+1] - first);
          a.file_position = FPOS_W'(position);
        end
      end
      default: begin
        // Reserved requests change nothing.
      end
    endcase
    a.entry_count = ENTRY_COUNT_W'(entries);
    return a;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] wanted,
                                      input logic [63:0] seen);
    if (seen !== wanted) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, wanted, seen);
      mismatches++;
    end
  endfunction

  // Results are compared before a request of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) key_table[i] = '0;
      for (int i = 0; i <= DEPTH; i++) offset_table[i] = '0;
      entries    = 0;
      data_end   = '0;
      data_bound = '1;
      pending_answers.delete();
      waiting    = 0;
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == DATA_BOUND_ADDR) begin
        data_bound = pwdata_i[OFFSET_W-1:0];
      end
      if (done_i) begin
        if (waiting == 0) begin
          $display("%0t: unexpected result, expected none, got ok %0b found %0b offset %0h",
                   $time, ok_i, found_i, value_offset_i);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          waiting--;
          check_field("ok", 64'(want.ok), 64'(ok_i));
          check_field("found", 64'(want.found), 64'(found_i));
          check_field("value_offset", 64'(want.value_offset), 64'(value_offset_i));
          check_field("value_bytes", 64'(want.value_bytes), 64'(value_bytes_i));
          check_field("file_position", 64'(want.file_position), 64'(file_position_i));
          check_field("entry_count", 64'(want.entry_count), 64'(entry_count_i));
        end
      end
      if (start_i && !busy_i) begin
        pending_answers.insert(pending_answers.size(),
                               predict_answer(cmd_e'(cmd_i), key_i, value_length_i));
        waiting++;
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorted key index lookup
// Drives clear, append, lookup and reserved requests with random pauses,
// rewrites data_bound between phases and fills the table to its depth once.
// A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import skil_pkg::*;
();

  localparam int unsigned DEPTH           = TABLE_DEPTH_DEF;
  localparam int unsigned RANDOM_REQUESTS = 150;
  localparam int unsigned MAX_GAP         = 18;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned RUN_LIMIT_NS    = 2_000_000;
  localparam logic [KEY_W-1:0]   KEY_MAX  = {KEY_W{1'b1}};
  localparam logic [PADDR_W-1:0] DATA_BOUND_ADDR = PADDR_W'({REG_DATA_BOUND, 2'b00});

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               cmd;
  logic [KEY_W-1:0]         key;
  logic [LENGTH_W-1:0]      value_length;
  logic                     done;
  logic                     ok;
  logic                     found;
  logic [OFFSET_W-1:0]      value_offset;
  logic [LENGTH_W-1:0]      value_bytes;
  logic [FPOS_W-1:0]        file_position;
  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  int unsigned              mismatches;
  int unsigned              outstanding;

  // Stimulus state: pause style, value length range and keys sent this phase.
  int unsigned      gap_mode;
  bit               wide_lengths;
  int unsigned      requests_sent;
  logic [KEY_W-1:0] stored_keys [$];

  sorted_key_index_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .key_i          (key),
    .value_length_i (value_length),
    .done_o         (done),
    .ok_o           (ok),
    .found_o        (found),
    .value_offset_o (value_offset),
    .value_bytes_o  (value_bytes),
    .file_position_o(file_position),
    .entry_count_o  (entry_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  index_lookup_checker #(
    .DEPTH(DEPTH)
  ) checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .key_i          (key),
    .value_length_i (value_length),
    .done_i         (done),
    .ok_i           (ok),
    .found_i        (found),
    .value_offset_i (value_offset),
    .value_bytes_i  (value_bytes),
    .file_position_i(file_position),
    .entry_count_i  (entry_count),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .errors_o       (mismatches),
    .pending_o      (outstanding)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Pause before a request: none, fully random, or mostly back to back.
  function automatic int unsigned draw_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, MAX_GAP);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  function automatic logic [LENGTH_W-1:0] draw_length();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return wide_lengths ? LENGTH_W'($urandom) : LENGTH_W'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] pick_bound();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 4000);
      3: return $urandom_range(0, 2000000);
      default: return $urandom;
    endcase
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic issue(input cmd_e op, input logic [KEY_W-1:0] k,
                       input logic [LENGTH_W-1:0] len);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    cmd          <= op;
    key          <= k;
    value_length <= len;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    requests_sent++;
  endtask

  // Drops start and waits until every outstanding result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  // Setup and access phase of one register write; called while idle.
  task automatic write_data_bound(input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DATA_BOUND_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A stray request inside an append sequence.
  task automatic stir_noise();
    case ($urandom_range(0, 3))
      0: issue(CMD_RESERVED, rand_key(), draw_length());
      1: issue(CMD_APPEND, rand_key(), draw_length());
      2: issue(CMD_LOOKUP, rand_key(), draw_length());
      default: issue(CMD_CLEAR, rand_key(), draw_length());
    endcase
  endtask

  // Appends n ascending keys, either spread over the key range or dense.
  task automatic fill_ascending(input int unsigned n, input bit spread, input bit noisy);
    logic [KEY_W-1:0] step_max;
    logic [KEY_W-1:0] k;
    step_max = spread ? KEY_MAX / (n + 1) : 64'd3;
    k = spread ? rand_key() % step_max : rand_key() >> 1;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) stir_noise();
      issue(CMD_APPEND, k, draw_length());
      stored_keys.insert(stored_keys.size(), k);
      k = k + 1 + rand_key() % step_max;
    end
  endtask

  // Lookups, mostly of keys sent in this phase, some neighbors and extremes.
  task automatic probe_keys(input int unsigned m);
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    repeat (m) begin
      pick = $urandom_range(0, 9);
      if (stored_keys.size() == 0 && pick < 7) pick = 7;
      if (pick <= 6) begin
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if (pick == 6) k = $urandom_range(0, 1) ? k + 1 : k - 1;
      end else if (pick == 7) begin
        k = rand_key();
      end else if (pick == 8) begin
        k = '0;
      end else begin
        k = KEY_MAX;
      end
      issue(CMD_LOOKUP, k, draw_length());
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned random_goal;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd           = CMD_CLEAR;
    key           = '0;
    value_length  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gap_mode      = 1;
    wide_lengths  = 1'b0;
    requests_sent = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table, reserved command and the key and length extremes.
    issue(CMD_LOOKUP, '0, '0);
    issue(CMD_LOOKUP, KEY_MAX, '1);
    issue(CMD_RESERVED, rand_key(), '1);
    issue(CMD_APPEND, '0, '0);
    issue(CMD_APPEND, 64'd5, '1);
    issue(CMD_APPEND, KEY_MAX, 16'd1);
    issue(CMD_LOOKUP, '0, '0);
    issue(CMD_LOOKUP, 64'd5, '0);
    issue(CMD_LOOKUP, KEY_MAX, '0);
    issue(CMD_LOOKUP, 64'd6, '0);
    // A key out of order is stored, but the search may pass it by.
    issue(CMD_APPEND, 64'd3, 16'd7);
    issue(CMD_LOOKUP, 64'd3, '0);
    issue(CMD_RESERVED, KEY_MAX, '0);
    issue(CMD_CLEAR, KEY_MAX, '1);
    issue(CMD_LOOKUP, 64'd5, '0);

    // A zero data bound lets only the first append through.
    settle();
    write_data_bound('0);
    issue(CMD_APPEND, 64'd10, 16'd100);
    issue(CMD_APPEND, 64'd20, 16'd1);
    issue(CMD_APPEND, 64'd20, '0);
    issue(CMD_LOOKUP, 64'd10, '0);
    settle();
    write_data_bound('1);
    issue(CMD_APPEND, 64'd20, '0);
    issue(CMD_LOOKUP, 64'd20, '0);
    issue(CMD_APPEND, 64'd20, 16'd9);
    issue(CMD_LOOKUP, 64'd20, '0);
    issue(CMD_CLEAR, '0, '0);

    // Random phases: clear, an ascending build with some noise, then lookups.
    random_goal = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < random_goal) begin
      settle();
      if ($urandom_range(0, 2) == 0) write_data_bound(pick_bound());
      gap_mode     = $urandom_range(0, 2);
      wide_lengths = $urandom_range(0, 1);
      issue(CMD_CLEAR, rand_key(), draw_length());
      stored_keys.delete();
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
      fill_ascending(n, $urandom_range(0, 3) != 0, 1'b1);
      probe_keys($urandom_range(1, n + 4));
    end

    // Fill the table to its depth, then appends are refused.
    settle();
    write_data_bound('1);
    gap_mode     = 2;
    wide_lengths = 1'b1;
    issue(CMD_CLEAR, rand_key(), draw_length());
    stored_keys.delete();
    fill_ascending(DEPTH, 1'b1, 1'b0);
    repeat (4) issue(CMD_APPEND, rand_key(), draw_length());
    issue(CMD_LOOKUP, stored_keys[0], '0);
    issue(CMD_LOOKUP, stored_keys[DEPTH-1], '0);
    probe_keys(80);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
